// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the turn controller RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define PTC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define PTC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/ptc_pkg.sv =====
// Package for the PI turn controller: widths, reset values, register codes,
// shared structs and the constants of the drive divider. No dependencies.
package ptc_pkg;

  // Field widths of the requests, results and registers.
  localparam int TARGET_W    = 16;
  localparam int HEADING_W   = 32;
  localparam int DRIVE_W     = 16;
  localparam int GAIN_W      = 16;
  localparam int FRAC_W      = 16;
  localparam int TOL_W       = 24;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 24;

  // Internal widths: error in 1/256 degree, saved error, integral.
  localparam int ERR_W   = 33;
  localparam int PREV_W  = 32;
  localparam int INTEG_W = 48;
  localparam int SUM_W   = 66;

  // Register reset values.
  localparam logic signed [GAIN_W-1:0] PROP_GAIN_RST  = 16'sd256;
  localparam logic signed [GAIN_W-1:0] INTEG_GAIN_RST = 16'sd256;
  localparam logic [FRAC_W-1:0]        WINDUP_RST     = 16'd51;
  localparam logic [TOL_W-1:0]         TOLERANCE_RST  = 24'd256;

  // Saturation limits.
  localparam logic signed [INTEG_W-1:0] INTEG_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [INTEG_W-1:0] INTEG_MIN = 48'sh8000_0000_0000;
  localparam logic signed [PREV_W-1:0]  PREV_MAX  = 32'sh7FFF_FFFF;
  localparam logic signed [PREV_W-1:0]  PREV_MIN  = 32'sh8000_0000;

  // Drive output: floor(sum / 51200) clamped to +-20480.
  // The clamp is decided on the raw sum; the in-range quotient is found as
  // floor(floor(sum / 2048) / 25) with a reciprocal multiply and one fixup.
  localparam logic signed [DRIVE_W-1:0] DRIVE_LIMIT = 16'sd20480;
  localparam logic signed [SUM_W-1:0]   SUM_HI      = 66'sd1048627200;
  localparam logic signed [SUM_W-1:0]   SUM_LO      = -66'sd1048576000;
  localparam int                        DIV_SHIFT   = 11;
  localparam int                        QUOT_W      = 20;
  localparam int                        RECIP_W     = 21;
  localparam int                        RECIP_SHIFT = 25;
  localparam logic [RECIP_W-1:0]        RECIP       = 21'd1342177;
  localparam logic [QUOT_W-1:0]         DIV_BY      = 20'd25;
  localparam logic signed [SUM_W-DIV_SHIFT-1:0] QUOT_BIAS = 55'sd512000;
  localparam logic [DRIVE_W-1:0]        DRIVE_BIAS  = 16'd20480;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PROP_GAIN        = 2'd0,
    REG_INTEG_GAIN       = 2'd1,
    REG_WINDUP_FRACTION  = 2'd2,
    REG_SETTLE_TOLERANCE = 2'd3
  } cfg_reg_t;

  // Configuration register set.
  typedef struct packed {
    logic signed [GAIN_W-1:0] prop_gain;
    logic signed [GAIN_W-1:0] integ_gain;
    logic [FRAC_W-1:0]        windup_fraction;
    logic [TOL_W-1:0]         settle_tolerance;
  } cfg_t;

  // Per-request result of the control stage, handed to the drive pipeline.
  typedef struct packed {
    logic                      done;
    logic signed [ERR_W-1:0]   err;
    logic signed [INTEG_W-1:0] integ;
  } ctrl_t;

endpackage

// ===== rtl/core/ptc_sample_if.sv =====
// Request channel of the turn controller: valid/ready plus target and heading.
// Depends on ptc_pkg for field widths.
interface ptc_sample_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [ptc_pkg::TARGET_W-1:0]     target_angle;
  logic signed [ptc_pkg::HEADING_W-1:0]    heading;

  modport source (output valid, output target_angle, output heading, input ready);
  modport sink   (input valid, input target_angle, input heading, output ready);
endinterface

// ===== rtl/core/ptc_command_if.sv =====
// Result channel of the turn controller: valid/ready plus drive and done flag.
// Depends on ptc_pkg for field widths.
interface ptc_command_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [ptc_pkg::DRIVE_W-1:0]   drive;
  logic                                 done_res;

  modport source (output valid, output drive, output done_res, input ready);
  modport sink   (input valid, input drive, input done_res, output ready);
endinterface

// ===== rtl/core/ptc_cfg.sv =====
// Configuration register file of the turn controller.
// Depends on ptc_pkg for the register codes and the cfg_t struct.
module ptc_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [ptc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [ptc_pkg::CFG_DATA_W-1:0]     cfg_data,
  output ptc_pkg::cfg_t                      cfg
);

  // Write one register per enabled cycle; each takes the low bits it needs.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prop_gain        <= ptc_pkg::PROP_GAIN_RST;
      cfg.integ_gain       <= ptc_pkg::INTEG_GAIN_RST;
      cfg.windup_fraction  <= ptc_pkg::WINDUP_RST;
      cfg.settle_tolerance <= ptc_pkg::TOLERANCE_RST;
    end else if (cfg_we) begin
      unique case (ptc_pkg::cfg_reg_t'(cfg_index))
        ptc_pkg::REG_PROP_GAIN: begin
          cfg.prop_gain <= $signed(cfg_data[ptc_pkg::GAIN_W-1:0]);
        end
        ptc_pkg::REG_INTEG_GAIN: begin
          cfg.integ_gain <= $signed(cfg_data[ptc_pkg::GAIN_W-1:0]);
        end
        ptc_pkg::REG_WINDUP_FRACTION: begin
          cfg.windup_fraction <= cfg_data[ptc_pkg::FRAC_W-1:0];
        end
        ptc_pkg::REG_SETTLE_TOLERANCE: begin
          cfg.settle_tolerance <= cfg_data[ptc_pkg::TOL_W-1:0];
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/ptc_ctrl.sv =====
// Input register and control stage: error, settle test, integral update.
// Depends on ptc_pkg for widths, limits and the cfg_t / ctrl_t structs.
module ptc_ctrl (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 adv,
  input  logic                                 in_valid,
  input  logic signed [ptc_pkg::TARGET_W-1:0]  in_target,
  input  logic signed [ptc_pkg::HEADING_W-1:0] in_heading,
  input  ptc_pkg::cfg_t                        cfg,
  output logic                                 res_valid,
  output ptc_pkg::ctrl_t                       res,
  output logic                                 running
);

  localparam int ERR_W   = ptc_pkg::ERR_W;
  localparam int PREV_W  = ptc_pkg::PREV_W;
  localparam int INTEG_W = ptc_pkg::INTEG_W;
  localparam int TGT_W   = ptc_pkg::TARGET_W;
  localparam int HEAD_W  = ptc_pkg::HEADING_W;

  // Input register.
  logic                     tgt_valid;
  logic signed [TGT_W-1:0]  tgt_q;
  logic signed [HEAD_W-1:0] head_q;

  // Move state.
  logic [HEAD_W-1:0]         start_heading;
  logic signed [INTEG_W-1:0] integral_sum;
  logic signed [PREV_W-1:0]  previous_error;

  // Control stage logic.
  logic                      fire;
  logic [HEAD_W-1:0]         start_eff;
  logic signed [PREV_W-1:0]  prev_eff;
  logic signed [INTEG_W-1:0] integ_eff;
  logic signed [ERR_W-1:0]   tgt_scaled;
  logic [HEAD_W-1:0]         head_diff;
  logic signed [ERR_W-1:0]   err;
  logic [ERR_W-1:0]          err_mag;
  logic [PREV_W-1:0]         prev_mag;
  logic [ERR_W:0]            settle_sum;
  logic                      keep_going;
  logic [TGT_W-1:0]          tgt_mag;
  logic [2*TGT_W-1:0]        band;
  logic                      in_band;
  logic signed [INTEG_W:0]   integ_add;
  logic signed [INTEG_W-1:0] integ_sat;
  logic signed [PREV_W-1:0]  err_sat;

  assign fire = adv && tgt_valid;

  // Capture a request whenever the pipeline moves.
  always_ff @(posedge clk) begin
    if (rst) begin
      tgt_valid <= 1'b0;
    end else if (adv) begin
      tgt_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      tgt_q  <= in_target;
      head_q <= in_heading;
    end
  end

  // When idle, the request starts a move from its own heading.
  always_comb begin
    start_eff  = running ? start_heading : head_q;
    tgt_scaled = {{(ERR_W-TGT_W-8){tgt_q[TGT_W-1]}}, tgt_q, 8'd0};
    prev_eff   = running ? previous_error
                         : {{(PREV_W-TGT_W-8){tgt_q[TGT_W-1]}}, tgt_q, 8'd0};
    integ_eff  = running ? integral_sum : '0;
  end

  // Error and the settle test.
  always_comb begin
    head_diff  = head_q - start_eff;
    err        = tgt_scaled - {head_diff[HEAD_W-1], head_diff};
    err_mag    = err[ERR_W-1] ? ERR_W'(-err) : err;
    prev_mag   = prev_eff[PREV_W-1] ? PREV_W'(-prev_eff) : prev_eff;
    settle_sum = {1'b0, err_mag} + {2'b0, prev_mag};
    keep_going = settle_sum > {{(ERR_W+1-ptc_pkg::TOL_W){1'b0}}, cfg.settle_tolerance};
  end

  // Integration band and the saturating integral add.
  always_comb begin
    tgt_mag   = tgt_q[TGT_W-1] ? TGT_W'(-tgt_q) : tgt_q;
    band      = tgt_mag * cfg.windup_fraction;
    in_band   = err_mag <= {{(ERR_W-2*TGT_W){1'b0}}, band};
    integ_add = {integ_eff[INTEG_W-1], integ_eff}
              + {{(INTEG_W+1-ERR_W){err[ERR_W-1]}}, err};
    if (integ_add[INTEG_W] != integ_add[INTEG_W-1]) begin
      integ_sat = integ_add[INTEG_W] ? ptc_pkg::INTEG_MIN : ptc_pkg::INTEG_MAX;
    end else begin
      integ_sat = integ_add[INTEG_W-1:0];
    end
    if (err[ERR_W-1] != err[ERR_W-2]) begin
      err_sat = err[ERR_W-1] ? ptc_pkg::PREV_MIN : ptc_pkg::PREV_MAX;
    end else begin
      err_sat = err[PREV_W-1:0];
    end
  end

  // Move state update, one request per cycle while the pipeline advances.
  always_ff @(posedge clk) begin
    if (rst) begin
      running        <= 1'b0;
      start_heading  <= '0;
      integral_sum   <= '0;
      previous_error <= '0;
    end else if (fire) begin
      if (keep_going) begin
        running        <= 1'b1;
        start_heading  <= start_eff;
        integral_sum   <= in_band ? integ_sat : integ_eff;
        previous_error <= err_sat;
      end else begin
        running <= 1'b0;
      end
    end
  end

  // Stage register toward the drive pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= tgt_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res.done  <= !keep_going;
      res.err   <= err;
      res.integ <= integ_eff;
    end
  end

endmodule

// ===== rtl/core/ptc_drive.sv =====
// Drive pipeline: gain products, sum, clamp and the divide by 51200.
// Depends on ptc_pkg for widths, divider constants and the ctrl_t struct.
module ptc_drive (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                adv,
  input  logic                                in_valid,
  input  ptc_pkg::ctrl_t                      ctl,
  input  logic signed [ptc_pkg::GAIN_W-1:0]   prop_gain,
  input  logic signed [ptc_pkg::GAIN_W-1:0]   integ_gain,
  output logic                                out_valid,
  output logic signed [ptc_pkg::DRIVE_W-1:0]  drive,
  output logic                                done_res
);

  localparam int NSTAGE  = 5;
  localparam int SUM_W   = ptc_pkg::SUM_W;
  localparam int ERR_W   = ptc_pkg::ERR_W;
  localparam int GAIN_W  = ptc_pkg::GAIN_W;
  localparam int HALF_W  = ptc_pkg::INTEG_W / 2;
  localparam int PE_W    = GAIN_W + ERR_W;
  localparam int PH_W    = GAIN_W + HALF_W;
  localparam int PL_W    = GAIN_W + HALF_W + 1;
  localparam int QUOT_W  = ptc_pkg::QUOT_W;
  localparam int PROD_W  = QUOT_W + ptc_pkg::RECIP_W;
  localparam int DRV_W   = ptc_pkg::DRIVE_W;
  localparam int MF_W    = SUM_W - ptc_pkg::DIV_SHIFT;

  logic [NSTAGE-1:0] vld;
  logic [NSTAGE-1:0] dn;

  // Stage 2: products.
  logic signed [PE_W-1:0] pe;
  logic signed [PH_W-1:0] ph;
  logic signed [PL_W-1:0] pl;
  // Stage 3: full sum.
  logic signed [SUM_W-1:0] pe_x;
  logic signed [SUM_W-1:0] sum_next;
  logic signed [SUM_W-1:0] sum_q;
  // Stage 4: clamp flags and biased quotient input.
  logic signed [MF_W-1:0] m_full;
  logic                   hi4, lo4, hi5, lo5;
  logic [QUOT_W-1:0]      m4, m5;
  // Stage 5: reciprocal estimate.
  logic [PROD_W-1:0]      prod;
  logic [DRV_W-1:0]       q0;
  // Output stage: fixup and select.
  logic [QUOT_W-1:0]      q25;
  logic [QUOT_W-1:0]      rem;
  logic [DRV_W-1:0]       qf;
  logic signed [DRV_W-1:0] drive_next;

  // Valid and done flags move with the pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NSTAGE-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dn <= {dn[NSTAGE-2:0], ctl.done};
    end
  end

  assign out_valid = vld[NSTAGE-1];
  assign done_res  = dn[NSTAGE-1];

  // Stage 2: proportional product and the integral product in two halves.
  always_ff @(posedge clk) begin
    if (adv) begin
      pe <= prop_gain * ctl.err;
      ph <= integ_gain * $signed(ctl.integ[2*HALF_W-1:HALF_W]);
      pl <= integ_gain * $signed({1'b0, ctl.integ[HALF_W-1:0]});
    end
  end

  // Stage 3: kp*e*200 + ki*integral.
  always_comb begin
    pe_x     = {{(SUM_W-PE_W){pe[PE_W-1]}}, pe};
    sum_next = (pe_x <<< 7) + (pe_x <<< 6) + (pe_x <<< 3)
             + {{(SUM_W-PH_W-HALF_W){ph[PH_W-1]}}, ph, {HALF_W{1'b0}}}
             + {{(SUM_W-PL_W){pl[PL_W-1]}}, pl};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sum_q <= sum_next;
    end
  end

  // Stage 4: clamp decisions and the biased floor(sum / 2048).
  assign m_full = $signed(sum_q[SUM_W-1:ptc_pkg::DIV_SHIFT]) + ptc_pkg::QUOT_BIAS;

  always_ff @(posedge clk) begin
    if (adv) begin
      hi4 <= sum_q >= ptc_pkg::SUM_HI;
      lo4 <= sum_q < ptc_pkg::SUM_LO;
      m4  <= m_full[QUOT_W-1:0];
    end
  end

  // Stage 5: quotient estimate by 25, at most one short.
  assign prod = m4 * ptc_pkg::RECIP;

  always_ff @(posedge clk) begin
    if (adv) begin
      hi5 <= hi4;
      lo5 <= lo4;
      m5  <= m4;
      q0  <= prod[ptc_pkg::RECIP_SHIFT +: DRV_W];
    end
  end

  // Output stage: correct the estimate, remove the bias, clamp; a finished move drives zero.
  always_comb begin
    q25 = QUOT_W'({q0, 4'd0}) + QUOT_W'({q0, 3'd0}) + QUOT_W'(q0);
    rem = m5 - q25;
    qf  = q0 + DRV_W'(rem >= ptc_pkg::DIV_BY);
    if (dn[NSTAGE-2]) begin
      drive_next = '0;
    end else if (hi5) begin
      drive_next = ptc_pkg::DRIVE_LIMIT;
    end else if (lo5) begin
      drive_next = -ptc_pkg::DRIVE_LIMIT;
    end else begin
      drive_next = $signed(qf - ptc_pkg::DRIVE_BIAS);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      drive <= drive_next;
    end
  end

endmodule

// ===== rtl/core/pi_turn_controller_antiwindup.sv =====
// Channel    Dir  Payload                    Handshake
// sample     in   target_angle, heading      valid / ready
// command    out  drive, done_res            valid / ready
// cfg        in   cfg_index, cfg_data        cfg_we, no back-pressure
//
// One request is taken every cycle while the pipeline is not stalled; its result
// passes the input register, the control stage and five drive stages.
// The move state loop (error, settle test, saturating integral) closes in
// the single control stage, which sets the one-per-cycle rate.
// Reset (rst, synchronous) clears the valid flags, the move state and the
// registers to their defaults. A stalled result freezes the whole pipeline.
// Top level of the PI turn controller; depends on ptc_pkg, the two channel
// interfaces, ptc_cfg, ptc_ctrl, ptc_drive and assert_macros.svh.
`include "assert_macros.svh"

module pi_turn_controller_antiwindup (
  input  logic                             clk,
  input  logic                             rst,
  ptc_sample_if.sink                       sample,
  ptc_command_if.source                    command,
  input  logic                             cfg_we,
  input  logic [ptc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [ptc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  ptc_pkg::cfg_t  cfg;
  ptc_pkg::ctrl_t ctrl_res;
  logic           ctrl_valid;
  logic           running;
  logic           adv;

  // The pipeline moves unless a finished result is held by the consumer.
  assign adv          = !command.valid || command.ready;
  assign sample.ready = adv;

  // Configuration registers.
  ptc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Input register and move state.
  ptc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .in_valid   (sample.valid),
    .in_target  (sample.target_angle),
    .in_heading (sample.heading),
    .cfg        (cfg),
    .res_valid  (ctrl_valid),
    .res        (ctrl_res),
    .running    (running)
  );

  // Drive computation and the result register.
  ptc_drive u_drive (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .in_valid   (ctrl_valid),
    .ctl        (ctrl_res),
    .prop_gain  (cfg.prop_gain),
    .integ_gain (cfg.integ_gain),
    .out_valid  (command.valid),
    .drive      (command.drive),
    .done_res   (command.done_res)
  );

  // A finished move always reports zero drive.
  `PTC_ASSERT_NOW(a_done_zero, clk, rst,
                  command.valid && command.done_res,
                  command.drive == '0,
                  "done result with nonzero drive")

  // A running move never commands beyond the clamp.
  `PTC_ASSERT_NOW(a_drive_range, clk, rst,
                  command.valid && !command.done_res,
                  ($signed(command.drive) <= ptc_pkg::DRIVE_LIMIT) &&
                  ($signed(command.drive) >= -ptc_pkg::DRIVE_LIMIT),
                  "drive outside clamp")

  // Once the control stage has ended a move the controller is idle.
  `PTC_ASSERT_NOW(a_done_idle, clk, rst,
                  ctrl_valid && ctrl_res.done,
                  !running,
                  "move ended but still running")

endmodule

// ===== test/tb_pi_turn_controller_antiwindup.sv =====
// Testbench for pi_turn_controller_antiwindup: drives target/heading requests,
// predicts each drive command in-house and checks every result field by field.
// Depends on ptc_pkg, ptc_sample_if, ptc_command_if and the controller RTL.
`timescale 1ns / 1ps

module tb_pi_turn_controller_antiwindup;
  import ptc_pkg::*;

  localparam int     CYCLE_LIMIT = 1_000_000;
  localparam int     DRAIN_CYCLES = 16;
  localparam int     GROWTH_STEPS = 70;
  localparam longint DRIVE_SCALE = 51200;
  localparam longint DRIVE_MAX = 20480;
  localparam longint INTEG_TOP = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint INTEG_BOTTOM = -INTEG_TOP - 1;
  localparam longint PREV_TOP = 64'sh0000_0000_7FFF_FFFF;
  localparam longint PREV_BOTTOM = -PREV_TOP - 1;
  localparam longint SAT_POS_ERR = 64'sd2147385345;   // 32767 * 65535
  localparam longint SAT_NEG_ERR = -64'sd2147450880;  // -32768 * 65535

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic                      done_res;
  } turn_cmd_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  ptc_sample_if  sample_bus();
  ptc_command_if command_bus();

  pi_turn_controller_antiwindup i_dut (
    .clk       (clk),
    .rst       (rst),
    .sample    (sample_bus),
    .command   (command_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Register copies and move state of the controller as predicted here.
  logic signed [GAIN_W-1:0] kp_gain = PROP_GAIN_RST;
  logic signed [GAIN_W-1:0] ki_gain = INTEG_GAIN_RST;
  logic [FRAC_W-1:0]        windup_frac = WINDUP_RST;
  logic [TOL_W-1:0]         settle_tol = TOLERANCE_RST;
  logic                     move_active = 1'b0;
  logic [HEADING_W-1:0]     move_start = '0;
  longint                   move_integral = 0;
  longint                   move_prev_err = 0;

  turn_cmd_t pending_commands[$];
  int        error_count = 0;
  int        items_sent = 0;
  bit        idle_on = 1'b1;
  int        stall_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint magnitude(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Gap length for either side: mostly none, sometimes short, rarely long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Target mix: half small turns, half anywhere in the 16-bit range.
  function automatic logic signed [TARGET_W-1:0] pick_target();
    if ($urandom_range(0, 1) == 0) return 16'($urandom);
    return 16'(int'($urandom_range(0, 400)) - 200);
  endfunction

  // One control tick: start a move when idle, then either drive or settle.
  task automatic compute_turn_command(input logic signed [TARGET_W-1:0] tgt,
                                      input logic [HEADING_W-1:0] head,
                                      output turn_cmd_t cmd);
    longint err, band, acc, quot, summed;
    logic [HEADING_W-1:0] moved;
    if (!move_active) begin
      move_active = 1'b1;
      move_start = head;
      move_integral = 0;
      move_prev_err = longint'(tgt) * 256;
    end
    moved = head - move_start;
    err = longint'(tgt) * 256 - longint'($signed(moved));
    cmd.drive = '0;
    cmd.done_res = 1'b1;
    if (magnitude(err) + magnitude(move_prev_err) > longint'(settle_tol)) begin
      // Floor division of the PI sum, then the clamp to +-DRIVE_MAX.
      acc = longint'(kp_gain) * err * 200 + longint'(ki_gain) * move_integral;
      quot = acc / DRIVE_SCALE;
      if ((acc % DRIVE_SCALE) != 0 && acc < 0) quot--;
      if (quot > DRIVE_MAX) quot = DRIVE_MAX;
      if (quot < -DRIVE_MAX) quot = -DRIVE_MAX;
      // Integrate only inside the windup band; the integral saturates at 48 bits.
      band = magnitude(longint'(tgt)) * longint'(windup_frac);
      if (magnitude(err) <= band) begin
        summed = move_integral + err;
        if (summed > INTEG_TOP) summed = INTEG_TOP;
        if (summed < INTEG_BOTTOM) summed = INTEG_BOTTOM;
        move_integral = summed;
      end
      if (err > PREV_TOP) move_prev_err = PREV_TOP;
      else if (err < PREV_BOTTOM) move_prev_err = PREV_BOTTOM;
      else move_prev_err = err;
      cmd.drive = 16'(quot);
      cmd.done_res = 1'b0;
    end else begin
      move_active = 1'b0;
    end
  endtask

  // Sends one request; called at a falling edge and returns at a falling edge.
  task automatic send_request(input logic signed [TARGET_W-1:0] tgt,
                              input logic [HEADING_W-1:0] head);
    int gap;
    turn_cmd_t want;
    gap = idle_on ? pick_gap() : 0;
    if (gap != 0) begin
      sample_bus.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample_bus.valid = 1'b1;
    sample_bus.target_angle = tgt;
    sample_bus.heading = head;
    do @(posedge clk); while (!sample_bus.ready);
    compute_turn_command(tgt, head, want);
    pending_commands.push_back(want);
    items_sent++;
    @(negedge clk);
  endtask

  // Brings the current move to rest: zero error until the settle test passes.
  task automatic settle_move(input logic signed [TARGET_W-1:0] tgt);
    while (move_active) send_request(tgt, move_start + 32'(longint'(tgt) * 256));
  endtask

  task automatic wait_for_drain();
    sample_bus.valid = 1'b0;
    while (pending_commands.size() != 0) @(negedge clk);
  endtask

  // Register write; bits above a register's width carry random filler.
  task automatic write_register(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(posedge clk);
    case (idx)
      REG_PROP_GAIN:        kp_gain = value[GAIN_W-1:0];
      REG_INTEG_GAIN:       ki_gain = value[GAIN_W-1:0];
      REG_WINDUP_FRACTION:  windup_frac = value[FRAC_W-1:0];
      REG_SETTLE_TOLERANCE: settle_tol = value[TOL_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // New register set, written only once the pipeline has emptied.
  task automatic program_controller(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki,
                                    input logic [FRAC_W-1:0] wf, input logic [TOL_W-1:0] tol);
    wait_for_drain();
    repeat (8) @(negedge clk);
    write_register(REG_PROP_GAIN, {8'($urandom), kp});
    write_register(REG_INTEG_GAIN, {8'($urandom), ki});
    write_register(REG_WINDUP_FRACTION, {8'($urandom), wf});
    write_register(REG_SETTLE_TOLERANCE, tol);
  endtask

  // Directed: instant settle, field extremes, saturated saved error, windup band.
  task automatic test_directed_extremes();
    idle_on = 1'b1;
    send_request(16'sd0, 32'h0000_0000);
    send_request(16'sd32767, 32'h7FFF_FFFF);
    send_request(16'sd32767, move_start + 32'h8000_0000);
    send_request(16'sd32767, move_start);
    settle_move(16'sd32767);
    send_request(-16'sd32768, 32'h8000_0000);
    send_request(-16'sd32768, move_start + 32'h7FFF_FFFF);
    send_request(-16'sd32768, 32'hFFFF_FFFF);
    settle_move(-16'sd32768);
    send_request(16'sd100, 32'hFFFF_FFFF);
    send_request(16'sd100, move_start + 32'd24600);
    send_request(16'sd100, move_start + 32'd10000);
    send_request(16'sd100, move_start + 32'd25600);
    send_request(-16'sd1, 32'h5555_5555);
    send_request(-16'sd1, 32'hAAAA_AAAA);
    settle_move(-16'sd1);
  endtask

  // Random moves over several register settings, with noise and broken moves.
  task automatic test_random_moves(input int quota);
    int base, steps, k;
    bit drained;
    longint span, offs;
    logic signed [TARGET_W-1:0] tgt;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: program_controller(PROP_GAIN_RST, INTEG_GAIN_RST, WINDUP_RST, TOLERANCE_RST);
        1: program_controller(16'h7FFF, 16'h8000, 16'hFFFF, 24'd0);
        2: program_controller(16'h8000, 16'h7FFF, 16'h0000, 24'hFF_FFFF);
        3: program_controller(16'h0000, 16'h0000, 16'($urandom), 24'($urandom_range(0, 4096)));
        default: program_controller(16'($urandom), 16'($urandom), 16'($urandom),
                                    ($urandom_range(0, 3) == 0) ? 24'($urandom)
                                                                : 24'($urandom_range(0, 4096)));
      endcase
      base = items_sent;
      drained = 1'b0;
      while (items_sent - base < quota / 6) begin
        idle_on = ($urandom_range(0, 99) < 85);
        // Hold the sender once per phase until every result is back.
        if (!drained && items_sent - base > quota / 12) begin
          wait_for_drain();
          drained = 1'b1;
        end
        if ($urandom_range(0, 99) < 20) begin
          repeat ($urandom_range(1, 4)) send_request(16'($urandom), $urandom);
        end else begin
          tgt = pick_target();
          send_request(tgt, $urandom);
          span = longint'(tgt) * 256;
          steps = $urandom_range(1, 16);
          // Heading closes in on the target with some sensor noise.
          for (k = 1; k <= steps; k++) begin
            offs = span - (span >>> k) + longint'($urandom_range(0, 64)) - 32;
            send_request(tgt, move_start + 32'(offs));
          end
          if ($urandom_range(0, 99) < 75) settle_move(tgt);
        end
      end
    end
  endtask

  // Long moves held at the band edge so the integral grows large both ways.
  task automatic test_integral_growth();
    program_controller(16'h7FFF, 16'h8000, 16'hFFFF, TOLERANCE_RST);
    idle_on = 1'b0;
    settle_move(16'sd1);
    send_request(16'sd32767, $urandom);
    repeat (GROWTH_STEPS)
      send_request(16'sd32767, move_start + 32'(64'sd8388352 - SAT_POS_ERR));
    settle_move(16'sd32767);
    send_request(-16'sd32768, $urandom);
    repeat (GROWTH_STEPS)
      send_request(-16'sd32768, move_start + 32'(-64'sd8388608 - SAT_NEG_ERR));
    settle_move(-16'sd32768);
    idle_on = 1'b1;
  endtask

  // Result side back-pressure: random stalls unless idling is switched off.
  always @(negedge clk) begin
    if (!idle_on) begin
      command_bus.ready = 1'b1;
    end else if (stall_left != 0) begin
      command_bus.ready = 1'b0;
      stall_left--;
    end else begin
      stall_left = pick_gap();
      command_bus.ready = (stall_left == 0);
      if (stall_left != 0) stall_left--;
    end
  end

  // Each accepted command is checked against the oldest prediction.
  always @(posedge clk) begin : command_check
    turn_cmd_t want;
    if (!rst && command_bus.valid && command_bus.ready) begin
      if (pending_commands.size() == 0) begin
        $error("unexpected command: drive %0d done_res %0b",
               command_bus.drive, command_bus.done_res);
        error_count++;
      end else begin
        want = pending_commands.pop_front();
        if (command_bus.drive !== want.drive) begin
          $error("drive: expected %0d, actual %0d", want.drive, command_bus.drive);
          error_count++;
        end
        if (command_bus.done_res !== want.done_res) begin
          $error("done_res: expected %0b, actual %0b", want.done_res, command_bus.done_res);
          error_count++;
        end
      end
    end
  end

  // Watchdog on total run length.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("[pi_turn_controller_antiwindup] ERROR");
    $finish;
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_PROP_GAIN;
    cfg_data = '0;
    sample_bus.valid = 1'b0;
    sample_bus.target_angle = '0;
    sample_bus.heading = '0;
    command_bus.ready = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_extremes();
    test_random_moves(720);
    test_integral_growth();

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("[pi_turn_controller_antiwindup] OK");
    end else begin
      $display("[pi_turn_controller_antiwindup] ERROR");
    end
    $finish;
  end

endmodule
